// File: design/readout_packet_deframer_defines.svh
// ---------------------------------------------------------------------------
// Readout packet deframer assertion macros
// Shared property wrappers, clocked on clk and disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef READOUT_PACKET_DEFRAMER_DEFINES_SVH
`define READOUT_PACKET_DEFRAMER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rpd_pkg.sv
// ---------------------------------------------------------------------------
// rpd_pkg
// Codes, flag values and field structs for the readout packet deframer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpd_pkg;

  localparam int WORD_W   = 64;
  localparam int KIND_W   = 3;
  localparam int ECODE_W  = 2;
  localparam int PKTNUM_W = 32;
  localparam int HITS_W   = 8;
  localparam int CHIP_W   = 3;
  localparam int BOARD_W  = 5;
  localparam int SMALL_W  = 6;
  localparam int WIDE_W   = 54;
  localparam int NARROW_W = 18;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_HEADER   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HIT      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TRAILER  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SEQUENCE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd4;

  // error codes
  localparam logic [ECODE_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ECODE_W-1:0] ERR_HEADER   = 2'd1;
  localparam logic [ECODE_W-1:0] ERR_TRAILER  = 2'd2;
  localparam logic [ECODE_W-1:0] ERR_SEQUENCE = 2'd3;

  // flag values in the first 32-bit word
  localparam logic [2:0] FLAG_HEADER   = 3'd6;
  localparam logic [2:0] FLAG_TRAILER  = 3'd7;
  localparam logic [3:0] FLAG_SEQUENCE = 4'd4;

  // every field set the decoder can pull out of one word
  typedef struct packed {
    logic        hdr_ok;
    logic        trl_ok;
    logic        seq_ok;
    logic [2:0]  hdr_status;
    logic [31:0] hdr_trigger;
    logic [15:0] hdr_timestamp;
    logic [7:0]  hdr_hits;
    logic [2:0]  hit_chip;
    logic [2:0]  hit_frame;
    logic [53:0] hit_raw;
    logic [2:0]  trl_chip;
    logic [4:0]  trl_board;
    logic [5:0]  trl_channel;
    logic [23:0] trl_frame;
    logic [17:0] trl_count;
    logic [4:0]  seq_board;
    logic [47:0] seq_count;
  } dec_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ECODE_W-1:0]  error_code;
    logic [PKTNUM_W-1:0] packet_number;
    logic [HITS_W-1:0]   hits_in_packet;
    logic [CHIP_W-1:0]   chip_id;
    logic [BOARD_W-1:0]  board_id;
    logic [SMALL_W-1:0]  small_code;
    logic [WIDE_W-1:0]   wide_value;
    logic [NARROW_W-1:0] narrow_value;
    logic                last_of_packet;
  } result_t;

endpackage

// File: design/rpd_decode.sv
// ---------------------------------------------------------------------------
// rpd_decode
// Splits one stream word into every field layout and checks the flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpd_decode
  import rpd_pkg::*;
(
  input  logic [WORD_W-1:0] word,
  output dec_t              dec
);

  logic [31:0] a;
  logic [31:0] b;

  assign a = word[63:32];
  assign b = word[31:0];

  always_comb begin
    dec               = '0;
    dec.hdr_ok        = (a[31:29] == FLAG_HEADER);
    dec.trl_ok        = (a[31:29] == FLAG_TRAILER);
    dec.seq_ok        = (a[31:28] == FLAG_SEQUENCE);
    // header
    dec.hdr_status    = a[28:26];
    dec.hdr_trigger   = {a[25:0], b[29:24]};
    dec.hdr_hits      = b[23:16];
    dec.hdr_timestamp = b[15:0];
    // hit
    dec.hit_chip      = a[29:27];
    dec.hit_frame     = a[26:24];
    dec.hit_raw       = {a[23:0], b[29:0]};
    // trailer
    dec.trl_chip      = b[29:27];
    dec.trl_board     = a[4:0];
    dec.trl_channel   = b[23:18];
    dec.trl_frame     = a[28:5];
    dec.trl_count     = b[17:0];
    // sequence
    dec.seq_board     = a[24:20];
    dec.seq_count     = {a[19:0], b[27:0]};
  end

endmodule

// File: design/readout_packet_deframer.sv
// The result of an accepted input item is in the output register in the following cycle.
// Throughput: one item per cycle while the output is not stalled; the single phase register and result register set it.
// A stalled result holds the output register, and input stall follows it.
// Reset (rst, synchronous, active high) returns to waiting for a header word with
// hit counts and the good-packet count at zero; no clearing pass is needed.
// ---------------------------------------------------------------------------
// readout_packet_deframer
// Decodes header, hit, trailer and sequence words of a readout packet stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "readout_packet_deframer_defines.svh"

module readout_packet_deframer
  import rpd_pkg::*;
#(
  parameter int PACKET_COUNT_WIDTH = 32
)(
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [WORD_W-1:0]   word,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [KIND_W-1:0]   kind,
  output logic [ECODE_W-1:0]  error_code,
  output logic [PKTNUM_W-1:0] packet_number,
  output logic [HITS_W-1:0]   hits_in_packet,
  output logic [CHIP_W-1:0]   chip_id,
  output logic [BOARD_W-1:0]  board_id,
  output logic [SMALL_W-1:0]  small_code,
  output logic [WIDE_W-1:0]   wide_value,
  output logic [NARROW_W-1:0] narrow_value,
  output logic                last_of_packet
);

  // packet framing phase; stopped is sticky until reset
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_HITS,
    PH_TRAILER,
    PH_SEQUENCE,
    PH_STOPPED
  } phase_t;

  phase_t                        phase;
  phase_t                        phase_next;
  logic [HITS_W-1:0]             hits_left;
  logic [HITS_W-1:0]             hits_left_next;
  logic [HITS_W-1:0]             hit_total;
  logic [HITS_W-1:0]             hit_total_next;
  logic [PACKET_COUNT_WIDTH-1:0] good_packets;
  logic [PACKET_COUNT_WIDTH-1:0] good_packets_next;

  dec_t                          dec;
  result_t                       res;
  result_t                       res_next;
  logic                          res_gen;    // this item yields a result
  logic                          in_accept;
  logic [PKTNUM_W-1:0]           pkt_num;

  // Field extraction and flag checks for the word at the port.
  rpd_decode u_decode (
    .word (word),
    .dec  (dec)
  );

  // The output register is free unless it holds a result that is being stalled,
  // so a new item is taken in the same cycle the old result leaves.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // packet_number shows the low 32 bits of the good-packet count
  generate
    if (PACKET_COUNT_WIDTH >= PKTNUM_W) begin : g_pkt_trunc
      assign pkt_num = good_packets[PKTNUM_W-1:0];
    end else begin : g_pkt_ext
      assign pkt_num = {{(PKTNUM_W-PACKET_COUNT_WIDTH){1'b0}}, good_packets};
    end
  endgenerate

  // Next state and result for the item at the port.
  always_comb begin
    phase_next             = phase;
    hits_left_next         = hits_left;
    hit_total_next         = hit_total;
    good_packets_next      = good_packets;
    res_gen                = 1'b1;
    res_next               = '0;
    res_next.packet_number = pkt_num;
    res_next.hits_in_packet = hit_total;

    case (phase)
      PH_HEADER: begin
        if (!dec.hdr_ok) begin
          // header error reports no hit count
          res_next.kind           = KIND_ERROR;
          res_next.error_code     = ERR_HEADER;
          res_next.hits_in_packet = '0;
          phase_next              = PH_STOPPED;
        end else begin
          hit_total_next          = dec.hdr_hits;
          hits_left_next          = dec.hdr_hits;
          res_next.kind           = KIND_HEADER;
          res_next.hits_in_packet = dec.hdr_hits;
          res_next.small_code     = {3'b000, dec.hdr_status};
          res_next.wide_value     = {22'd0, dec.hdr_trigger};
          res_next.narrow_value   = {2'b00, dec.hdr_timestamp};
          // empty packet: next word is the trailer
          phase_next = (dec.hdr_hits != '0) ? PH_HITS : PH_TRAILER;
        end
      end
      PH_HITS: begin
        // hit words carry no flag
        res_next.kind       = KIND_HIT;
        res_next.chip_id    = dec.hit_chip;
        res_next.small_code = {3'b000, dec.hit_frame};
        res_next.wide_value = dec.hit_raw;
        hits_left_next      = hits_left - 8'd1;
        if (hits_left_next == '0) begin
          phase_next = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        if (!dec.trl_ok) begin
          res_next.kind       = KIND_ERROR;
          res_next.error_code = ERR_TRAILER;
          phase_next          = PH_STOPPED;
        end else begin
          res_next.kind         = KIND_TRAILER;
          res_next.chip_id      = dec.trl_chip;
          res_next.board_id     = dec.trl_board;
          res_next.small_code   = dec.trl_channel;
          res_next.wide_value   = {30'd0, dec.trl_frame};
          res_next.narrow_value = dec.trl_count;
          phase_next            = PH_SEQUENCE;
        end
      end
      PH_SEQUENCE: begin
        if (!dec.seq_ok) begin
          res_next.kind       = KIND_ERROR;
          res_next.error_code = ERR_SEQUENCE;
          phase_next          = PH_STOPPED;
        end else begin
          res_next.kind           = KIND_SEQUENCE;
          res_next.board_id       = dec.seq_board;
          res_next.wide_value     = {6'd0, dec.seq_count};
          res_next.last_of_packet = 1'b1;
          good_packets_next       = good_packets + PACKET_COUNT_WIDTH'(1);
          hits_left_next          = '0;
          phase_next              = PH_HEADER;
        end
      end
      PH_STOPPED: begin
        // words are taken and dropped
        res_gen = 1'b0;
      end
      default: begin
        res_gen    = 1'b0;
        phase_next = PH_STOPPED;
      end
    endcase
  end

  // Framing state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      hits_left    <= '0;
      hit_total    <= '0;
      good_packets <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (in_accept) begin
        phase        <= phase_next;
        hits_left    <= hits_left_next;
        hit_total    <= hit_total_next;
        good_packets <= good_packets_next;
      end
      if (!in_stall) begin
        out_valid <= in_accept && res_gen;
      end
      if (in_accept && res_gen) begin
        res <= res_next;
      end
    end
  end

  assign kind           = res.kind;
  assign error_code     = res.error_code;
  assign packet_number  = res.packet_number;
  assign hits_in_packet = res.hits_in_packet;
  assign chip_id        = res.chip_id;
  assign board_id       = res.board_id;
  assign small_code     = res.small_code;
  assign wide_value     = res.wide_value;
  assign narrow_value   = res.narrow_value;
  assign last_of_packet = res.last_of_packet;

  // Checks on the framing logic.
  `RPD_ASSERT_NEXT(a_error_stops, in_accept && res_gen && res_next.kind == KIND_ERROR, phase == PH_STOPPED, "error item did not stop the deframer")
  `RPD_ASSERT_NEXT(a_stop_sticky, phase == PH_STOPPED, phase == PH_STOPPED, "left stopped phase without reset")
  `RPD_ASSERT_SAME(a_code_on_error, out_valid && kind != KIND_ERROR, error_code == ERR_NONE, "error code on a non-error result")
  `RPD_ASSERT_SAME(a_last_on_seq, out_valid && last_of_packet, kind == KIND_SEQUENCE, "end of packet marked on a non-sequence result")

endmodule

// File: sim/rpd_deframer_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpd_deframer_checker
// Watches both channels of the readout packet deframer, decodes every
// accepted word on its own and compares each result field by field.
// ---------------------------------------------------------------------------

module rpd_deframer_checker
  import rpd_pkg::*;
#(
  parameter int COUNT_W = 32
)(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [WORD_W-1:0]   word,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [KIND_W-1:0]   kind,
  input  logic [ECODE_W-1:0]  error_code,
  input  logic [PKTNUM_W-1:0] packet_number,
  input  logic [HITS_W-1:0]   hits_in_packet,
  input  logic [CHIP_W-1:0]   chip_id,
  input  logic [BOARD_W-1:0]  board_id,
  input  logic [SMALL_W-1:0]  small_code,
  input  logic [WIDE_W-1:0]   wide_value,
  input  logic [NARROW_W-1:0] narrow_value,
  input  logic                last_of_packet,
  output int                  fail_count,
  output int                  pending,
  output int                  checked,
  output int                  packets_closed
);

  typedef enum logic [2:0] {
    WANT_HEADER,
    WANT_HITS,
    WANT_TRAILER,
    WANT_SEQUENCE,
    HALTED
  } stream_phase_e;

  stream_phase_e      phase;
  logic [HITS_W-1:0]  hits_left;
  logic [HITS_W-1:0]  hit_total;
  logic [COUNT_W-1:0] good_count;
  result_t            decoded_q[$];

  initial begin
    fail_count     = 0;
    pending        = 0;
    checked        = 0;
    packets_closed = 0;
  end

  // decode one word against the current phase; 0 when nothing comes out
  function automatic logic decode_word(input logic [WORD_W-1:0] w, output result_t r);
    logic [31:0] a;
    logic [31:0] b;
    a = w[63:32];
    b = w[31:0];
    r = '0;
    if (phase == HALTED) return 1'b0;
    r.packet_number  = good_count[PKTNUM_W-1:0];
    r.hits_in_packet = hit_total;
    case (phase)
      WANT_HEADER: begin
        if (a[31:29] != FLAG_HEADER) begin
          r.kind           = KIND_ERROR;
          r.error_code     = ERR_HEADER;
          r.hits_in_packet = '0;
          phase            = HALTED;
          return 1'b1;
        end
        hit_total        = b[23:16];
        hits_left        = b[23:16];
        r.kind           = KIND_HEADER;
        r.hits_in_packet = b[23:16];
        r.small_code     = SMALL_W'(a[28:26]);
        r.wide_value     = WIDE_W'({a[25:0], b[29:24]});
        r.narrow_value   = NARROW_W'(b[15:0]);
        phase            = (b[23:16] != '0) ? WANT_HITS : WANT_TRAILER;
      end
      WANT_HITS: begin
        r.kind       = KIND_HIT;
        r.chip_id    = a[29:27];
        r.small_code = SMALL_W'(a[26:24]);
        r.wide_value = {a[23:0], b[29:0]};
        hits_left    = hits_left - HITS_W'(1);
        if (hits_left == '0) phase = WANT_TRAILER;
      end
      WANT_TRAILER: begin
        if (a[31:29] != FLAG_TRAILER) begin
          r.kind       = KIND_ERROR;
          r.error_code = ERR_TRAILER;
          phase        = HALTED;
          return 1'b1;
        end
        r.kind         = KIND_TRAILER;
        r.chip_id      = b[29:27];
        r.board_id     = a[4:0];
        r.small_code   = b[23:18];
        r.wide_value   = WIDE_W'(a[28:5]);
        r.narrow_value = b[17:0];
        phase          = WANT_SEQUENCE;
      end
      default: begin
        if (a[31:28] != FLAG_SEQUENCE) begin
          r.kind       = KIND_ERROR;
          r.error_code = ERR_SEQUENCE;
          phase        = HALTED;
          return 1'b1;
        end
        r.kind           = KIND_SEQUENCE;
        r.board_id       = a[24:20];
        r.wide_value     = WIDE_W'({a[19:0], b[27:0]});
        r.last_of_packet = 1'b1;
        good_count       = good_count + COUNT_W'(1);
        hits_left        = '0;
        phase            = WANT_HEADER;
      end
    endcase
    return 1'b1;
  endfunction

  task automatic note_field(input string name, input logic [63:0] got,
                            input logic [63:0] want);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("result %0d %s: expected %0h, got %0h", checked, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t next_result;
    if (rst) begin
      phase      = WANT_HEADER;
      hits_left  = '0;
      hit_total  = '0;
      good_count = '0;
      decoded_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d: none expected, got kind %0d", checked, kind);
        end else begin
          want = decoded_q.pop_front();
          note_field("kind", 64'(kind), 64'(want.kind));
          note_field("error_code", 64'(error_code), 64'(want.error_code));
          note_field("packet_number", 64'(packet_number), 64'(want.packet_number));
          note_field("hits_in_packet", 64'(hits_in_packet), 64'(want.hits_in_packet));
          note_field("chip_id", 64'(chip_id), 64'(want.chip_id));
          note_field("board_id", 64'(board_id), 64'(want.board_id));
          note_field("small_code", 64'(small_code), 64'(want.small_code));
          note_field("wide_value", 64'(wide_value), 64'(want.wide_value));
          note_field("narrow_value", 64'(narrow_value), 64'(want.narrow_value));
          note_field("last_of_packet", 64'(last_of_packet), 64'(want.last_of_packet));
          if (want.kind == KIND_SEQUENCE) packets_closed++;
        end
        checked++;
      end
      if (in_valid && !in_stall) begin
        if (decode_word(word, next_result)) decoded_q.push_back(next_result);
      end
    end
    pending = decoded_q.size();
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Feeds packet streams into the readout packet deframer with random gaps
// and back-pressure; the checker beside it decodes and compares each result.
// ---------------------------------------------------------------------------

module tb_top;
  import rpd_pkg::*;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [WORD_W-1:0]   word      = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [KIND_W-1:0]   kind;
  logic [ECODE_W-1:0]  error_code;
  logic [PKTNUM_W-1:0] packet_number;
  logic [HITS_W-1:0]   hits_in_packet;
  logic [CHIP_W-1:0]   chip_id;
  logic [BOARD_W-1:0]  board_id;
  logic [SMALL_W-1:0]  small_code;
  logic [WIDE_W-1:0]   wide_value;
  logic [NARROW_W-1:0] narrow_value;
  logic                last_of_packet;

  int fail_count;
  int pending;
  int checked;
  int packets_closed;

  // sender and receiver each flip between gappy and back-to-back stretches
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;
  int   words_fed = 0;

  readout_packet_deframer dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .word           (word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .error_code     (error_code),
    .packet_number  (packet_number),
    .hits_in_packet (hits_in_packet),
    .chip_id        (chip_id),
    .board_id       (board_id),
    .small_code     (small_code),
    .wide_value     (wide_value),
    .narrow_value   (narrow_value),
    .last_of_packet (last_of_packet)
  );

  rpd_deframer_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .word           (word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .error_code     (error_code),
    .packet_number  (packet_number),
    .hits_in_packet (hits_in_packet),
    .chip_id        (chip_id),
    .board_id       (board_id),
    .small_code     (small_code),
    .wide_value     (wide_value),
    .narrow_value   (narrow_value),
    .last_of_packet (last_of_packet),
    .fail_count     (fail_count),
    .pending        (pending),
    .checked        (checked),
    .packets_closed (packets_closed)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: well beyond the slowest legal run (every item paying the
  // longest gap plus the longest stall).
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // --- word builders: flag fields fixed, everything else random ---------
  function automatic logic [WORD_W-1:0] header_word(input logic [HITS_W-1:0] nhits);
    logic [WORD_W-1:0] w;
    w          = {$urandom, $urandom};
    w[63:61]   = FLAG_HEADER;
    w[23:16]   = nhits;
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] trailer_word();
    logic [WORD_W-1:0] w;
    w        = {$urandom, $urandom};
    w[63:61] = FLAG_TRAILER;
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] sequence_word();
    logic [WORD_W-1:0] w;
    w        = {$urandom, $urandom};
    w[63:60] = FLAG_SEQUENCE;
    return w;
  endfunction

  // Present one item after a random gap and hold it until it is taken.
  // The payload is scrambled while valid is low, so idle words must be ignored.
  task automatic feed_word(input logic [WORD_W-1:0] w);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 16);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
      word     <= {$urandom, $urandom};
    end
    @(negedge clk);
    in_valid <= 1'b1;
    word     <= w;
    do @(posedge clk); while (!(in_valid && !in_stall));
    words_fed++;
  endtask

  // one well-formed packet with random content
  task automatic feed_packet(input int nhits);
    feed_word(header_word(HITS_W'(nhits)));
    repeat (nhits) feed_word({$urandom, $urandom});
    feed_word(trailer_word());
    feed_word(sequence_word());
  endtask

  // Receiver: random stall before each result, with stall-free stretches.
  initial begin : sink
    int hold;
    forever begin
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      hold = rx_steady ? 0 : $urandom_range(0, 16);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin : stimulus
    logic [ECODE_W-1:0] stop_at;
    logic [WORD_W-1:0]  w;
    logic [2:0]         bad3;
    logic [3:0]         bad4;
    int                 big_at;
    int                 r;

    // reset: released on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed ---------------------------------------------------------
    // Empty packet with all-zero fields: zero hit count goes straight to
    // the trailer.
    feed_word({FLAG_HEADER, 61'd0});
    feed_word({FLAG_TRAILER, 61'd0});
    feed_word({FLAG_SEQUENCE, 60'd0});
    // Single hit, every other field at its maximum.
    feed_word({FLAG_HEADER, 29'h1fff_ffff, 8'hff, 8'h01, 16'hffff});
    feed_word('1);
    feed_word('1);
    feed_word({FLAG_SEQUENCE, 60'hfff_ffff_ffff_ffff});
    // Two hits with alternating bit patterns.
    feed_word({FLAG_HEADER, 29'h0aaa_aaaa, 8'h55, 8'h02, 16'h5555});
    feed_word(64'h5555_5555_5555_5555);
    feed_word(64'haaaa_aaaa_aaaa_aaaa);
    feed_word({FLAG_TRAILER, 29'h1555_5555, 32'haaaa_aaaa});
    feed_word({FLAG_SEQUENCE, 28'h555_5555, 32'h5555_5555});

    // --- random packets ---------------------------------------------------
    // Mostly short packets; one packet somewhere carries the full 255 hits.
    big_at = $urandom_range(20, 120);
    while (words_fed < 1300) begin
      if (big_at == 0) begin
        feed_packet(255);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 20)      feed_packet(0);
        else if (r < 85) feed_packet($urandom_range(1, 6));
        else             feed_packet($urandom_range(7, 40));
      end
      big_at--;
    end

    // --- closing error ----------------------------------------------------
    // A flag mismatch halts the block until reset, so only one can be hit
    // per run; pick which stage breaks.
    stop_at = ECODE_W'($urandom_range(ERR_HEADER, ERR_SEQUENCE));
    case (stop_at)
      ERR_HEADER: begin
        w = header_word(HITS_W'($urandom));
        do bad3 = 3'($urandom); while (bad3 == FLAG_HEADER);
        w[63:61] = bad3;
        feed_word(w);
      end
      ERR_TRAILER: begin
        r = $urandom_range(0, 3);
        feed_word(header_word(HITS_W'(r)));
        repeat (r) feed_word({$urandom, $urandom});
        w = trailer_word();
        do bad3 = 3'($urandom); while (bad3 == FLAG_TRAILER);
        w[63:61] = bad3;
        feed_word(w);
      end
      default: begin
        r = $urandom_range(0, 3);
        feed_word(header_word(HITS_W'(r)));
        repeat (r) feed_word({$urandom, $urandom});
        feed_word(trailer_word());
        w = sequence_word();
        do bad4 = 4'($urandom); while (bad4 == FLAG_SEQUENCE);
        w[63:60] = bad4;
        feed_word(w);
      end
    endcase
    // once halted, even well-formed headers must be swallowed silently
    repeat (20) begin
      if ($urandom_range(0, 1) != 0) feed_word(header_word(HITS_W'($urandom_range(0, 3))));
      else                          feed_word({$urandom, $urandom});
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then wait for any stray result to show up
    do @(negedge clk); while (pending != 0);
    repeat (8) @(negedge clk);

    $display("Fed %0d words; checked %0d results over %0d good packets.",
             words_fed, checked, packets_closed);
    $display("Run closed on a flag error of code %0d, then 20 words into the halted block.",
             stop_at);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: readout_packet_deframer.f
+incdir+design
design/rpd_pkg.sv
design/rpd_decode.sv
design/readout_packet_deframer.sv
sim/rpd_deframer_checker.sv
sim/tb_top.sv
